// ===== design/rsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types, constants and helpers for the reverse subsequence matcher.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int MAX_QUERY      = 16;
    localparam int MAX_PATH       = 4096;
    localparam int CHAR_W         = 8;
    localparam int POS_W          = 12;
    localparam int LEN_W          = 13;
    localparam int QLEN_W         = 5;
    localparam int QIDX_W         = 4;
    localparam int COUNT_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;

    // ascii upper case range and the offset to lower case
    localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_LOW  = 2'd0,
        REG_QUERY_HIGH = 2'd1,
        REG_QUERY_LEN  = 2'd2,
        REG_EXACT_CASE = 2'd3
    } cfg_reg_t;

    // live configuration seen by the matcher
    typedef struct packed {
        logic [2*CFG_DATA_W-1:0] query_chars;
        logic [QLEN_W-1:0]       query_length;
        logic                    exact_case;
    } cfg_t;

    // one result record
    typedef struct packed {
        logic [COUNT_W-1:0] candidate_number;
        logic               is_match;
        logic [POS_W-1:0]   span_start;
        logic [POS_W-1:0]   span_end;
        logic [LEN_W-1:0]   path_length;
        logic               empty_query;
    } result_t;

    // fold A-Z to a-z unless exact compare is selected
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic exact);
        logic [CHAR_W-1:0] r;
        r = c;
        if (!exact && (c >= UPPER_A) && (c <= UPPER_Z))
        begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

    // pick query character idx out of the packed query bytes
    function automatic logic [CHAR_W-1:0] query_byte(
        input logic [2*CFG_DATA_W-1:0] chars,
        input logic [QIDX_W-1:0]       idx);
        return chars[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ===== design/rsm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_cfg_regs
// Configuration register file: query bytes, query length and case mode.
// ----------------------------------------------------------------------------
module rsm_cfg_regs
    import rsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [CFG_DATA_W-1:0] query_low_reg;
    logic [CFG_DATA_W-1:0] query_high_reg;
    logic [QLEN_W-1:0]     query_len_reg;
    logic                  exact_case_reg;
    logic                  wr_en;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_low_reg  <= '0;
            query_high_reg <= '0;
            query_len_reg  <= '0;
            exact_case_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_QUERY_LOW:  query_low_reg  <= cfg_data;
                REG_QUERY_HIGH: query_high_reg <= cfg_data;
                REG_QUERY_LEN:  query_len_reg  <= cfg_data[QLEN_W-1:0];
                REG_EXACT_CASE: exact_case_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.query_chars  = {query_high_reg, query_low_reg};
    assign cfg.query_length = query_len_reg;
    assign cfg.exact_case   = exact_case_reg;

endmodule

// ===== design/rsm_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_match
// Per-candidate match state and the single-byte greedy backward compare.
// ----------------------------------------------------------------------------
module rsm_match
    import rsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] path_char,
    input  logic [POS_W-1:0]  char_position,
    input  cfg_t              cfg,
    output logic              close,
    output result_t           result
);

    logic                in_cand_reg,   in_cand_next;
    logic [QLEN_W-1:0]   q_left_reg,    q_left_next;
    logic                end_seen_reg,  end_seen_next;
    logic [POS_W-1:0]    end_pos_reg,   end_pos_next;
    logic [POS_W-1:0]    start_pos_reg, start_pos_next;
    logic [LEN_W-1:0]    cand_len_reg,  cand_len_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;

    logic [QLEN_W-1:0]   q_len_sat;
    logic [LEN_W-1:0]    len_raw;
    logic [QLEN_W-1:0]   q_left_eff;
    logic                end_seen_eff;
    logic [POS_W-1:0]    end_pos_eff;
    logic [POS_W-1:0]    start_pos_eff;
    logic [LEN_W-1:0]    cand_len_eff;
    logic [QLEN_W-1:0]   q_left_dec;
    logic [CHAR_W-1:0]   q_char;
    logic                hit;
    logic                matched;

    assign close = (char_position == '0);

    // start-of-candidate values
    assign q_len_sat = (cfg.query_length > QLEN_W'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY)
                                                               : cfg.query_length;
    assign len_raw   = {1'b0, char_position} + LEN_W'(1);

    always_comb
    begin
        if (in_cand_reg)
        begin
            q_left_eff    = q_left_reg;
            end_seen_eff  = end_seen_reg;
            end_pos_eff   = end_pos_reg;
            start_pos_eff = start_pos_reg;
            cand_len_eff  = cand_len_reg;
        end
        else
        begin
            q_left_eff    = q_len_sat;
            end_seen_eff  = 1'b0;
            end_pos_eff   = '0;
            start_pos_eff = '0;
            cand_len_eff  = (len_raw > LEN_W'(MAX_PATH)) ? LEN_W'(MAX_PATH) : len_raw;
        end
    end

    // compare this byte with the next query character from the back
    assign q_left_dec = q_left_eff - QLEN_W'(1);
    assign q_char     = query_byte(cfg.query_chars, q_left_dec[QIDX_W-1:0]);
    assign hit        = (q_left_eff != '0) &&
                        (fold_char(path_char, cfg.exact_case) ==
                         fold_char(q_char, cfg.exact_case));

    // next state
    always_comb
    begin
        q_left_next    = q_left_eff;
        end_seen_next  = end_seen_eff;
        end_pos_next   = end_pos_eff;
        start_pos_next = start_pos_eff;
        cand_len_next  = cand_len_eff;
        in_cand_next   = !close;
        count_next     = close ? count_reg + COUNT_W'(1) : count_reg;
        if (hit)
        begin
            if (!end_seen_eff)
            begin
                end_seen_next = 1'b1;
                end_pos_next  = char_position;
            end
            if (q_left_eff == QLEN_W'(1))
            begin
                start_pos_next = char_position;
            end
            q_left_next = q_left_dec;
        end
    end

    // result record for a closing byte
    assign matched                 = end_seen_next && (q_left_next == '0);
    assign result.candidate_number = count_reg;
    assign result.is_match         = matched;
    assign result.span_start       = matched ? start_pos_next : '0;
    assign result.span_end         = matched ? end_pos_next : '0;
    assign result.path_length      = cand_len_next;
    assign result.empty_query      = (cfg.query_length == '0);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cand_reg <= 1'b0;
            q_left_reg  <= '0;
            end_seen_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            in_cand_reg  <= in_cand_next;
            q_left_reg   <= q_left_next;
            end_seen_reg <= end_seen_next;
            count_reg    <= count_next;
        end
    end

    // span and length tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_pos_reg   <= '0;
            start_pos_reg <= '0;
            cand_len_reg  <= '0;
        end
        else if (step)
        begin
            end_pos_reg   <= end_pos_next;
            start_pos_reg <= start_pos_next;
            cand_len_reg  <= cand_len_next;
        end
    end

endmodule

// ===== design/reverse_subsequence_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reverse_subsequence_matcher_core
// Streams candidate path bytes last to first and emits one match record
// per candidate.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | input     | in_valid / in_stall  | path_char, char_position
//  out     | output    | out_valid / out_stall| candidate record (6 fields)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one input beat per cycle while in_stall is low; a closing beat (position
//  zero) passes the input register, then its record the output register.
//  the rate is set by the compare stage between the input register and the
//  result register: one byte compare and one query pointer step per cycle.
//  reset clears all control state; there is no clearing pass.
//  a stalled record holds the output register; only a closing beat then waits,
//  other beats keep flowing.
// ----------------------------------------------------------------------------
module reverse_subsequence_matcher_core
    import rsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAR_W-1:0]     path_char,
    input  logic [POS_W-1:0]      char_position,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COUNT_W-1:0]    candidate_number,
    output logic                  is_match,
    output logic [POS_W-1:0]      span_start,
    output logic [POS_W-1:0]      span_end,
    output logic [LEN_W-1:0]      path_length,
    output logic                  empty_query,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    logic              s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0] s1_char_reg;
    logic [POS_W-1:0]  s1_pos_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           result;
    logic              close;
    logic              adv;
    logic              in_take;

    rsm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsm_match u_match (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (adv),
        .path_char     (s1_char_reg),
        .char_position (s1_pos_reg),
        .cfg           (cfg),
        .close         (close),
        .result        (result)
    );

    // handshake control
    assign adv      = s1_valid_reg && (!close || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv && close)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input beat register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= path_char;
            s1_pos_reg  <= char_position;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv && close)
        begin
            out_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign candidate_number = out_reg.candidate_number;
    assign is_match         = out_reg.is_match;
    assign span_start       = out_reg.span_start;
    assign span_end         = out_reg.span_end;
    assign path_length      = out_reg.path_length;
    assign empty_query      = out_reg.empty_query;

    // a record appears only after a closing beat advanced
    a_rise_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(adv && close))
        else $error("record appeared without a closing beat");

    // an empty input register never stalls the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    // a taken record with no new close leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !(adv && close)) |=> !out_valid_reg)
        else $error("record repeated after being taken");

    // a delivered record always has a nonzero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.path_length != '0))
        else $error("record with zero path length");

endmodule

// ===== test/rsm_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_record_checker
// Watches the input, output and register channels of the matcher. It keeps a
// shadow copy of the registers and the matcher state, works out the record
// for every closing beat and compares each record leaving the block, field
// by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module rsm_record_checker
    import rsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [CHAR_W-1:0]     path_char,
    input  logic [POS_W-1:0]      char_position,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [COUNT_W-1:0]    candidate_number,
    input  logic                  is_match,
    input  logic [POS_W-1:0]      span_start,
    input  logic [POS_W-1:0]      span_end,
    input  logic [LEN_W-1:0]      path_length,
    input  logic                  empty_query,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    records_pending
);

    // shadow registers
    logic [2*CFG_DATA_W-1:0] query_chars;
    logic [QLEN_W-1:0]       query_len;
    logic                    exact_mode;

    // shadow matcher state
    logic                    open_cand;
    logic [QLEN_W-1:0]       chars_left;
    logic                    first_hit;
    logic [POS_W-1:0]        hit_end;
    logic [POS_W-1:0]        hit_start;
    logic [LEN_W-1:0]        cand_bytes;
    logic [COUNT_W-1:0]      cand_index;

    result_t                 expected_records[$];
    result_t                 new_record;
    result_t                 want;

    initial error_count = 0;

    // compare key of a byte under the current case mode
    function automatic logic [CHAR_W-1:0] case_key(input logic [CHAR_W-1:0] c);
        if (!exact_mode && (c >= UPPER_A) && (c <= UPPER_Z))
        begin
            return c + CASE_DELTA;
        end
        return c;
    endfunction

    // advance the shadow matcher by one beat; returns 1 when a record is due
    function automatic bit score_beat(input logic [CHAR_W-1:0] c,
                                      input logic [POS_W-1:0] p,
                                      output result_t rec);
        logic [QIDX_W-1:0] qi;
        logic              matched;
        rec = '0;
        // first beat opens a candidate; query length clamps at the maximum
        if (!open_cand)
        begin
            open_cand  = 1'b1;
            chars_left = (query_len > QLEN_W'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY) : query_len;
            first_hit  = 1'b0;
            hit_end    = '0;
            hit_start  = '0;
            // a 12-bit position plus one never exceeds the path limit
            cand_bytes = LEN_W'(p) + LEN_W'(1);
        end
        // greedy backwards compare against the next query byte, read live
        if (chars_left != '0)
        begin
            qi = QIDX_W'(chars_left - 1'b1);
            if (case_key(c) == case_key(query_chars[qi*CHAR_W +: CHAR_W]))
            begin
                if (!first_hit)
                begin
                    first_hit = 1'b1;
                    hit_end   = p;
                end
                if (chars_left == QLEN_W'(1))
                begin
                    hit_start = p;
                end
                chars_left = chars_left - 1'b1;
            end
        end
        if (p != '0)
        begin
            return 1'b0;
        end
        // closing beat
        matched              = first_hit && (chars_left == '0);
        rec.candidate_number = cand_index;
        rec.is_match         = matched;
        rec.span_start       = matched ? hit_start : '0;
        rec.span_end         = matched ? hit_end : '0;
        rec.path_length      = cand_bytes;
        rec.empty_query      = (query_len == '0);
        open_cand            = 1'b0;
        cand_index           = cand_index + 1'b1;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val, input logic [15:0] num);
        if (exp_val !== act_val)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("record %0d: %s expected %0h, got %0h", num, name, exp_val, act_val);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_chars = '0;
            query_len   = '0;
            exact_mode  = 1'b0;
            open_cand   = 1'b0;
            chars_left  = '0;
            first_hit   = 1'b0;
            hit_end     = '0;
            hit_start   = '0;
            cand_bytes  = '0;
            cand_index  = '0;
            expected_records.delete();
        end
        else
        begin
            // register beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_QUERY_LOW:  query_chars[CFG_DATA_W-1:0] = cfg_data;
                    REG_QUERY_HIGH: query_chars[2*CFG_DATA_W-1:CFG_DATA_W] = cfg_data;
                    REG_QUERY_LEN:  query_len = cfg_data[QLEN_W-1:0];
                    REG_EXACT_CASE: exact_mode = cfg_data[0];
                    default: ;
                endcase
            end
            // record beat leaving the block
            if (out_valid && !out_stall)
            begin
                if (expected_records.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("unexpected record %0d", candidate_number);
                    end
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("candidate_number", want.candidate_number, candidate_number,
                                want.candidate_number);
                    check_field("is_match", 16'(want.is_match), 16'(is_match),
                                want.candidate_number);
                    check_field("span_start", 16'(want.span_start), 16'(span_start),
                                want.candidate_number);
                    check_field("span_end", 16'(want.span_end), 16'(span_end),
                                want.candidate_number);
                    check_field("path_length", 16'(want.path_length), 16'(path_length),
                                want.candidate_number);
                    check_field("empty_query", 16'(want.empty_query), 16'(empty_query),
                                want.candidate_number);
                end
            end
            // path byte beat entering the block
            if (in_valid && !in_stall)
            begin
                if (score_beat(path_char, char_position, new_record))
                begin
                    expected_records.push_back(new_record);
                end
            end
        end
        records_pending = expected_records.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the reverse subsequence matcher. A short directed
// run covers case folding, exact compare, partial matches, empty and
// oversized queries, the longest path, a register change inside a candidate
// and odd position order. Random phases then stream candidates built mostly
// from the query bytes under several register settings, with random idling
// on both channels, a long output hold-off and a burst with no idling.
// ----------------------------------------------------------------------------
module tb_top;
    import rsm_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CHAR_W-1:0]     path_char;
    logic [POS_W-1:0]      char_position;
    logic                  out_valid;
    logic                  out_stall;
    logic [COUNT_W-1:0]    candidate_number;
    logic                  is_match;
    logic [POS_W-1:0]      span_start;
    logic [POS_W-1:0]      span_end;
    logic [LEN_W-1:0]      path_length;
    logic                  empty_query;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    error_count;
    int                    records_pending;

    // stimulus bookkeeping
    logic [2*CFG_DATA_W-1:0] cur_query;
    logic [QLEN_W-1:0]       cur_qlen;
    int                      walk;
    int                      beats_sent;
    bit                      no_idle;
    int                      hold_request;

    reverse_subsequence_matcher_core dut (.*);

    rsm_record_checker record_check (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // output side: random stall, or a counted hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (no_idle)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 31);
            end
        end
    end

    // one path byte beat, with a random gap ahead of it
    task automatic send_beat(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] p);
        while (!no_idle && ($urandom_range(0, 99) < 31))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        path_char     <= c;
        char_position <= p;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        beats_sent++;
        @(negedge clk);
    endtask

    // stop sending and wait until every record is back, plus pipeline slack
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (records_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic set_query(input logic [2*CFG_DATA_W-1:0] chars,
                             input logic [QLEN_W-1:0] qlen, input logic exact);
        cur_query = chars;
        cur_qlen  = qlen;
        write_reg(REG_QUERY_LOW, chars[CFG_DATA_W-1:0]);
        write_reg(REG_QUERY_HIGH, chars[2*CFG_DATA_W-1:CFG_DATA_W]);
        write_reg(REG_QUERY_LEN, CFG_DATA_W'(qlen));
        write_reg(REG_EXACT_CASE, CFG_DATA_W'(exact));
        cfg_valid <= 1'b0;
    endtask

    // sixteen random letters of random case
    function automatic logic [2*CFG_DATA_W-1:0] letter_query();
        logic [2*CFG_DATA_W-1:0] q;
        for (int k = 0; k < MAX_QUERY; k++)
        begin
            q[k*CHAR_W +: CHAR_W] = UPPER_A + CHAR_W'($urandom_range(0, 25))
                                  + ($urandom_range(0, 1) ? CASE_DELTA : 8'h00);
        end
        return q;
    endfunction

    // path byte: mostly the next query byte walking backwards, case flipped
    // at random, otherwise noise
    function automatic logic [CHAR_W-1:0] next_path_char();
        logic [CHAR_W-1:0] b;
        int                eff;
        eff = (cur_qlen > MAX_QUERY) ? MAX_QUERY : int'(cur_qlen);
        if ((eff == 0) || ($urandom_range(0, 99) < 30))
        begin
            return CHAR_W'($urandom_range(0, 255));
        end
        if (walk < 0)
        begin
            walk = eff - 1;
        end
        b = cur_query[walk*CHAR_W +: CHAR_W];
        walk--;
        if (((b | CASE_DELTA) >= 8'h61) && ((b | CASE_DELTA) <= 8'h7A) && $urandom_range(0, 1))
        begin
            b = b ^ CASE_DELTA;
        end
        return b;
    endfunction

    // one candidate of len bytes; irregular ones carry random positions
    task automatic send_candidate(input int len, input bit irregular);
        logic [POS_W-1:0] p;
        walk = ((cur_qlen > MAX_QUERY) ? MAX_QUERY : int'(cur_qlen)) - 1;
        for (int k = len - 1; k >= 0; k--)
        begin
            p = (irregular && (k != 0)) ? POS_W'($urandom_range(1, 4095)) : POS_W'(k);
            send_beat(next_path_char(), p);
        end
    endtask

    initial
    begin
        int  target;
        int  pick;
        bit  paused;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        path_char     = '0;
        char_position = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_QUERY_LOW;
        cfg_data      = '0;
        cur_query     = '0;
        cur_qlen      = '0;
        walk          = -1;
        beats_sent    = 0;
        no_idle       = 1'b0;
        hold_request  = 0;
        paused        = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty query after reset, single-byte candidate
        send_beat(8'h00, '0);
        settle();

        // query "aZ" folded: full match, half match, longest path
        set_query(128'h5A61, 5'd2, 1'b0);
        send_beat(8'h7A, 12'd1);
        send_beat(8'h41, 12'd0);
        send_beat(8'h7A, 12'd0);
        send_beat(8'hFF, 12'hFFF);
        send_beat(8'h00, 12'd0);
        settle();

        // same query exact: case now matters
        set_query(128'h5A61, 5'd2, 1'b1);
        send_beat(8'h7A, 12'd1);
        send_beat(8'h41, 12'd0);
        // register change inside an open candidate
        send_beat(8'h5A, 12'd1);
        settle();
        set_query(128'h5A61, 5'd0, 1'b1);
        send_beat(8'h61, 12'd0);
        settle();

        // oversized query length clamps to sixteen zero bytes
        set_query('0, 5'd31, 1'b1);
        for (int k = MAX_QUERY - 1; k >= 0; k--)
        begin
            send_beat(8'h00, POS_W'(k));
        end
        settle();

        // random phases under different register settings
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_query(letter_query(), 5'd3, 1'b0);
                1: set_query(letter_query(), 5'd16, 1'b1);
                2: set_query(letter_query(), 5'd1, 1'b0);
                3: set_query({$urandom, $urandom, $urandom, $urandom},
                             QLEN_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                4: set_query(letter_query(), 5'd0, 1'b0);
                5: set_query(letter_query(), 5'd31, 1'b0);
                6: set_query(letter_query(), QLEN_W'($urandom_range(1, 8)),
                             1'($urandom_range(0, 1)));
                default: set_query({$urandom, $urandom, $urandom, $urandom},
                                   QLEN_W'($urandom_range(2, 16)), 1'b0);
            endcase
            target = beats_sent + 150;
            // long output hold-off while closing beats keep coming
            if (phase == 2)
            begin
                hold_request = 400;
                repeat (60) send_beat(CHAR_W'($urandom_range(0, 255)), '0);
            end
            while (beats_sent < target)
            begin
                // sender pause until every record is back
                if ((phase == 5) && !paused && (beats_sent > target - 100))
                begin
                    settle();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    send_candidate($urandom_range(2, 6), 1'b1);
                end
                else if (pick < 7)
                begin
                    send_candidate($urandom_range(40, 120), 1'b0);
                end
                else
                begin
                    send_candidate($urandom_range(1, 20), 1'b0);
                end
            end
            // leave a candidate open across the next register change
            if (phase % 2 == 1)
            begin
                repeat (3) send_beat(next_path_char(), POS_W'($urandom_range(1, 4095)));
            end
            settle();
        end

        // back-to-back single-byte candidates with no idling on either side
        no_idle = 1'b1;
        repeat (150) send_beat(CHAR_W'($urandom_range(0, 255)), '0);
        settle();
        no_idle = 1'b0;
        repeat (8) @(negedge clk);

        if ((error_count == 0) && (records_pending == 0))
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
